// ===== hdl/lsp_pkg.sv =====
// ----------------------------------------------------------------------------
// lsp_pkg
// Shared widths, operation and status codes and a control struct for the
// stack with peek.
// ----------------------------------------------------------------------------
package lsp_pkg;

    localparam int DATA_W    = 32;
    localparam int FUNC_W    = 2;
    localparam int DIST_W    = 7;
    localparam int STATUS_W  = 2;
    localparam int FILL_W    = 8;
    localparam int DEPTH_DEF = 128;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUSH   = 2'd0,
        FUNC_POP    = 2'd1,
        FUNC_PEEK   = 2'd2,
        FUNC_STATUS = 2'd3
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK    = 2'd0,
        STS_FULL  = 2'd1,
        STS_EMPTY = 2'd2,
        STS_RANGE = 2'd3
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic load_out;
    } t_ctl_cmd;

endpackage

// ===== hdl/lsp_ifs.sv =====
// ----------------------------------------------------------------------------
// lsp_ifs
// Valid/ready channels for operation words and result words.
// ----------------------------------------------------------------------------
interface lsp_in_if import lsp_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [FUNC_W-1:0]        func;
    logic signed [DATA_W-1:0] push_value;
    logic [DIST_W-1:0]        peek_distance;

    modport source (output valid, func, push_value, peek_distance, input ready);
    modport sink   (input valid, func, push_value, peek_distance, output ready);
endinterface

interface lsp_out_if import lsp_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] read_value;
    logic [STATUS_W-1:0]      status;
    logic                     is_empty;
    logic                     is_full;
    logic [FILL_W-1:0]        fill_count;

    modport source (output valid, read_value, status, is_empty, is_full, fill_count,
                    input ready);
    modport sink   (input valid, read_value, status, is_empty, is_full, fill_count,
                    output ready);
endinterface

// ===== hdl/lsp_ctrl.sv =====
// ----------------------------------------------------------------------------
// lsp_ctrl
// Handshake controller: takes one operation word, waits for the stack read,
// then loads the result register once it is free.
// ----------------------------------------------------------------------------
module lsp_ctrl import lsp_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_ctl_cmd o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free       = !r_out_valid || i_out_ready;
    assign o_in_ready     = (r_state == ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_cmd.accept   = i_in_valid && o_in_ready;
    assign o_cmd.load_out = (r_state == ST_EXEC) && out_free;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (o_cmd.accept) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out)   n_out_valid = 1'b1;
        else if (i_out_ready) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== hdl/lsp_dp.sv =====
// ----------------------------------------------------------------------------
// lsp_dp
// Stack datapath: entry memory, fill counter, status decode and the
// result register.
// ----------------------------------------------------------------------------
module lsp_dp import lsp_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_ctl_cmd                 i_cmd,
    input  logic [FUNC_W-1:0]        i_func,
    input  logic signed [DATA_W-1:0] i_push_value,
    input  logic [DIST_W-1:0]        i_peek_distance,
    output logic signed [DATA_W-1:0] o_read_value,
    output logic [STATUS_W-1:0]      o_status,
    output logic                     o_is_empty,
    output logic                     o_is_full,
    output logic [FILL_W-1:0]        o_fill_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int WW = (CW > DIST_W) ? CW : DIST_W;
    localparam int FW = (CW > FILL_W) ? CW : FILL_W;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    logic [CW-1:0]       r_count, n_count;
    logic [STATUS_W-1:0] r_op_status, n_op_status;
    logic                r_use_rd, n_use_rd;

    logic          wr_en, rd_en;
    logic [AW-1:0] rd_addr;
    logic [WW-1:0] cnt_ext, dist_ext, top_idx, peek_idx;
    logic [FW-1:0] cnt_wide;
    logic          is_full_now;

    assign cnt_ext     = WW'(r_count);
    assign dist_ext    = WW'(i_peek_distance);
    assign top_idx     = cnt_ext - WW'(1);
    assign peek_idx    = top_idx - dist_ext;
    assign is_full_now = (r_count == CW'(DEPTH));

    always_comb begin
        n_count     = r_count;
        n_op_status = STS_OK;
        n_use_rd    = 1'b0;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = top_idx[AW-1:0];
        case (t_func'(i_func))
            FUNC_PUSH: begin
                if (is_full_now) begin
                    n_op_status = STS_FULL;
                end else begin
                    wr_en   = i_cmd.accept;
                    n_count = r_count + CW'(1);
                end
            end
            FUNC_POP: begin
                if (r_count == '0) begin
                    n_op_status = STS_EMPTY;
                end else begin
                    rd_en    = i_cmd.accept;
                    n_use_rd = 1'b1;
                    n_count  = r_count - CW'(1);
                end
            end
            FUNC_PEEK: begin
                if (dist_ext >= cnt_ext) begin
                    n_op_status = STS_RANGE;
                end else begin
                    rd_en    = i_cmd.accept;
                    n_use_rd = 1'b1;
                    rd_addr  = peek_idx[AW-1:0];
                end
            end
            default: ;
        endcase
    end

    // push writes at the old fill count
    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[r_count[AW-1:0]] <= i_push_value;
        if (rd_en) r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.accept) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op_status <= n_op_status;
            r_use_rd    <= n_use_rd;
        end
    end

    assign cnt_wide = FW'(r_count);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_read_value <= r_use_rd ? r_rd_data : '0;
            o_status     <= r_op_status;
            o_is_empty   <= (r_count == '0);
            o_is_full    <= is_full_now;
            o_fill_count <= cnt_wide[FILL_W-1:0];
        end
    end

endmodule

// ===== hdl/lifo_stack_with_peek.sv =====
// A result word is read into the read stage registers, then loaded into the result
// register; no new operation is taken until that load, as the controller keeps one
// operation in flight; a stalled result holds the next operation in the read stage.
// Reset (synchronous, active low) empties the stack and drops any pending
// result; the entry memory itself is not cleared.
// ----------------------------------------------------------------------------
// lifo_stack_with_peek
// Fixed-depth stack of signed words with push, pop, peek and status access.
// ----------------------------------------------------------------------------
module lifo_stack_with_peek import lsp_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lsp_in_if.sink    i_in,
    lsp_out_if.source o_out
);

    t_ctl_cmd cmd;

    lsp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd)
    );

    lsp_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_func          (i_in.func),
        .i_push_value    (i_in.push_value),
        .i_peek_distance (i_in.peek_distance),
        .o_read_value    (o_out.read_value),
        .o_status        (o_out.status),
        .o_is_empty      (o_out.is_empty),
        .o_is_full       (o_out.is_full),
        .o_fill_count    (o_out.fill_count)
    );

    // one word in flight at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> !i_in.ready)
        else $error("operation taken while another is in flight");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !(o_out.is_empty && o_out.is_full))
        else $error("empty and full flags both set");

    a_full_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.status == STS_FULL) |-> o_out.is_full)
        else $error("push rejected while not full");

    a_empty_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.status == STS_EMPTY) |->
            o_out.is_empty && (o_out.read_value == '0))
        else $error("pop rejected while not empty");

endmodule
